### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/sef_pkg.sv
// Shared constants, types and codes of the Sobel edge frame filter.
package sef_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 512;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 11;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] POS_STEPS = 5'd20;
    localparam logic [DIV_CNT_W-1:0] EQ_STEPS  = 5'd8;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EQUALIZE = 2'd2;
    localparam logic [1:0] CFG_INVERT   = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_DEN_W-1:0] rem_init;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_POS   = 8'b00000010,
        S_ADDR  = 8'b00000100,
        S_READ  = 8'b00001000,
        S_LEVEL = 8'b00010000,
        S_EQDIV = 8'b00100000,
        S_ACC   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;
endpackage

### hw/rtl/sef_div.sv
// Restoring divider, one quotient bit per cycle, shared by position and level math.
module sef_div
    import sef_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_dvd;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    assign trial = {r_rem, r_dvd[DIV_NUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= i_req.steps;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_dvd <= i_req.num;
            r_den <= i_req.den;
        end else if (r_run) begin
            r_rem <= qbit ? DIV_DEN_W'(trial - {1'b0, r_den}) : DIV_DEN_W'(trial);
            r_dvd <= {r_dvd[DIV_NUM_W-2:0], qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem;
endmodule

### hw/rtl/sef_frame_store.sv
// Frame store: one write port, one read port with registered read data.
module sef_frame_store
    import sef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);
    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/sobel_edge_frame_filter_top.sv
// Top level of the Sobel edge frame filter: control, level stretch and gradient sum.
//
// A request is taken at a rising edge with start high and busy low. A push
// request (command 0) writes the pixel into the frame store in that cycle
// and busy stays low; pushes into a full frame are dropped. A fetch request
// (command 1) on a full frame raises busy, splits the output position into
// line and column on the shared bit-serial divider, then visits the nine
// neighbors one at a time through the single store read port, each through
// S_ADDR, S_READ, S_LEVEL and S_ACC; with equalize on, a neighbor level
// within the frame minimum and maximum also runs the stretch, 8 more divider
// steps in S_EQDIV. The result shows on o_edge_value and o_last_of_frame for
// exactly one cycle with o_valid high; the receiver cannot stall, so take
// it in that cycle. A fetch before the frame is full gives no result. The
// frame store needs no clearing pass: only written entries are ever read.
`include "assert_macros.svh"
module sobel_edge_frame_filter_top
    import sef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    output logic [7:0]  o_edge_value,
    output logic        o_last_of_frame,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    // configuration
    logic [10:0] r_frame_width;
    logic [9:0]  r_frame_height;
    logic        r_equalize_on;
    logic        r_invert_on;

    // frame bookkeeping
    logic [7:0]  r_min_level;
    logic [7:0]  r_max_level;
    logic [19:0] r_load_count;
    logic [19:0] r_emit_count;

    t_state      r_state;
    logic        r_last;
    logic [9:0]  r_x, r_y;
    logic [9:0]  r_xm, r_xp, r_ym, r_yp;
    logic [1:0]  r_row, r_col;
    logic [ADDR_W-1:0] r_raddr;
    logic [7:0]  r_level;
    logic signed [11:0] r_gx, r_gy;
    logic        r_out_valid;
    logic [7:0]  r_out_edge;
    logic        r_out_last;

    logic [10:0] eff_w;
    logic [9:0]  eff_h;
    logic [19:0] area;
    logic        full;
    logic        accept;
    logic        push_we;
    logic [20:0] emit_inc;
    logic [19:0] pos;
    logic [9:0]  row_val, col_val;
    logic [20:0] addr_full;
    logic [7:0]  rd_data;
    logic [7:0]  diff;
    logic [15:0] eq_num;
    logic        eq_div;
    logic [7:0]  direct_level;
    logic [8:0]  wlevel;
    logic signed [11:0] gx_term, gy_term;
    logic [10:0] abs_gx, abs_gy;
    logic [11:0] mag;
    logic [7:0]  mag_clamp;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    // clamp the size to at least 1 and at most the store dimensions
    always_comb begin
        if (r_frame_width == 11'd0) begin
            eff_w = 11'd1;
        end else if (r_frame_width > 11'(MAX_WIDTH)) begin
            eff_w = 11'(MAX_WIDTH);
        end else begin
            eff_w = r_frame_width;
        end
        if (r_frame_height == 10'd0) begin
            eff_h = 10'd1;
        end else if (r_frame_height > 10'(MAX_HEIGHT)) begin
            eff_h = 10'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    assign area     = 20'(eff_w * eff_h);
    assign full     = (r_load_count >= area);
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign push_we  = accept && (i_command == CMD_PUSH) && !full;
    assign emit_inc = {1'b0, r_emit_count} + 21'd1;
    // past a shrunk area, hold on the last pixel
    assign pos      = (r_emit_count > area - 20'd1) ? area - 20'd1 : r_emit_count;

    sef_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_load_count[ADDR_W-1:0]),
        .i_wdata (i_pixel),
        .i_raddr (r_raddr),
        .o_rdata (rd_data)
    );

    // level stretch: quotient of 255*(p-min) by (max-min) stays below 256,
    // so preload the upper byte as remainder and run eight steps
    assign diff   = rd_data - r_min_level;
    assign eq_num = {diff, 8'd0} - {8'd0, diff};
    always_comb begin
        eq_div       = 1'b0;
        direct_level = rd_data;
        if (r_equalize_on) begin
            if (r_max_level <= r_min_level) begin
                direct_level = r_min_level;
            end else if (rd_data < r_min_level) begin
                direct_level = 8'd0;
            end else if (rd_data > r_max_level) begin
                direct_level = 8'd255;
            end else begin
                eq_div = 1'b1;
            end
        end
    end

    always_comb begin
        div_req = '0;
        if (accept && (i_command == CMD_FETCH) && full) begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.num      = pos;
            div_req.den      = eff_w;
            div_req.steps    = POS_STEPS;
        end else if ((r_state == S_LEVEL) && eq_div) begin
            div_req.start    = 1'b1;
            div_req.rem_init = DIV_DEN_W'(eq_num[15:8]);
            div_req.num      = {eq_num[7:0], 12'd0};
            div_req.den      = DIV_DEN_W'(r_max_level - r_min_level);
            div_req.steps    = EQ_STEPS;
        end
    end

    sef_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // neighbor address from the current tap
    always_comb begin
        case (r_row)
            2'd0:    row_val = r_ym;
            2'd1:    row_val = r_y;
            default: row_val = r_yp;
        endcase
        case (r_col)
            2'd0:    col_val = r_xm;
            2'd1:    col_val = r_x;
            default: col_val = r_xp;
        endcase
    end
    assign addr_full = 21'(row_val * eff_w) + 21'(col_val);

    // Sobel weights: gx by column sign, gy by row sign, middle row (gx) and middle column (gy) doubled
    assign wlevel = (r_row == 2'd1) ? {r_level, 1'b0} : {1'b0, r_level};
    always_comb begin
        case (r_col)
            2'd0:    gx_term = -$signed({3'b000, wlevel});
            2'd2:    gx_term = $signed({3'b000, wlevel});
            default: gx_term = 12'sd0;
        endcase
        case (r_row)
            2'd0:    gy_term = (r_col == 2'd1) ? $signed({3'b000, r_level, 1'b0})
                                               : $signed({4'b0000, r_level});
            2'd2:    gy_term = (r_col == 2'd1) ? -$signed({3'b000, r_level, 1'b0})
                                               : -$signed({4'b0000, r_level});
            default: gy_term = 12'sd0;
        endcase
    end

    assign abs_gx    = r_gx[11] ? 11'(-r_gx) : r_gx[10:0];
    assign abs_gy    = r_gy[11] ? 11'(-r_gy) : r_gy[10:0];
    assign mag       = {1'b0, abs_gx} + {1'b0, abs_gy};
    assign mag_clamp = (mag > 12'd255) ? 8'd255 : mag[7:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 10'd480;
            r_equalize_on  <= 1'b0;
            r_invert_on    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:    r_frame_width  <= i_cfg_data;
                CFG_HEIGHT:   r_frame_height <= i_cfg_data[9:0];
                CFG_EQUALIZE: r_equalize_on  <= i_cfg_data[0];
                CFG_INVERT:   r_invert_on    <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_level  <= 8'd255;
            r_max_level  <= 8'd0;
            r_load_count <= '0;
            r_emit_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (push_we) begin
                        if (i_pixel < r_min_level) r_min_level <= i_pixel;
                        if (i_pixel > r_max_level) r_max_level <= i_pixel;
                        r_load_count <= r_load_count + 20'd1;
                    end
                    if (div_req.start) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    if (div_rsp.done) r_state <= S_ADDR;
                end
                S_ADDR:  r_state <= S_READ;
                S_READ:  r_state <= S_LEVEL;
                S_LEVEL: r_state <= eq_div ? S_EQDIV : S_ACC;
                S_EQDIV: begin
                    if (div_rsp.done) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= ((r_row == 2'd2) && (r_col == 2'd2)) ? S_OUT : S_ADDR;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    if (r_last) begin
                        r_load_count <= '0;
                        r_emit_count <= '0;
                        r_min_level  <= 8'd255;
                        r_max_level  <= 8'd0;
                    end else begin
                        r_emit_count <= r_emit_count + 20'd1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_last <= (emit_inc >= {1'b0, area});
            end
            S_POS: begin
                r_y   <= div_rsp.quot[9:0];
                r_x   <= div_rsp.rem[9:0];
                r_xm  <= (div_rsp.rem[9:0] == 10'd0) ? 10'd0 : div_rsp.rem[9:0] - 10'd1;
                r_xp  <= ({1'b0, div_rsp.rem[9:0]} + 11'd1 >= eff_w)
                         ? div_rsp.rem[9:0] : div_rsp.rem[9:0] + 10'd1;
                r_ym  <= (div_rsp.quot[9:0] == 10'd0) ? 10'd0 : div_rsp.quot[9:0] - 10'd1;
                r_yp  <= ({1'b0, div_rsp.quot[9:0]} + 11'd1 >= {1'b0, eff_h})
                         ? div_rsp.quot[9:0] : div_rsp.quot[9:0] + 10'd1;
                r_row <= 2'd0;
                r_col <= 2'd0;
                r_gx  <= 12'sd0;
                r_gy  <= 12'sd0;
            end
            S_ADDR:  r_raddr <= addr_full[ADDR_W-1:0];
            S_LEVEL: r_level <= direct_level;
            S_EQDIV: r_level <= div_rsp.quot[7:0];
            S_ACC: begin
                r_gx <= r_gx + gx_term;
                r_gy <= r_gy + gy_term;
                // advance to the next tap
                if (r_col == 2'd2) begin
                    r_col <= 2'd0;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
            S_OUT: begin
                r_out_edge <= r_invert_on ? 8'd255 - mag_clamp : mag_clamp;
                r_out_last <= r_last;
            end
            default: ;
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_edge_value    = r_out_edge;
    assign o_last_of_frame = r_out_last;

    `ASSERT_CLK(a_out_from_final, i_clk, i_rst_n, r_out_valid |-> $past(r_state == S_OUT), "result strobe without final step")
    `ASSERT_NEVER(a_write_while_busy, i_clk, i_rst_n, push_we && busy, "store write during fetch")
    `ASSERT_CLK(a_frame_end_clears, i_clk, i_rst_n, (r_out_valid && r_out_last) |-> (r_load_count == 20'd0), "frame end did not clear load count")
    `ASSERT_CLK(a_div_done_owner, i_clk, i_rst_n, div_rsp.done |-> (r_state == S_POS || r_state == S_EQDIV), "divider finished outside a wait state")
endmodule
